### rtl/core/csw_avg_pkg.sv
// Package for the calibrated sensor window average: field widths, register
// indexes, reset values and the lane control bundle.
// No dependencies; every other file of the block imports it.
`default_nettype none

package csw_avg_pkg;

    // Field widths.
    localparam int MEAN_W  = 13;
    localparam int RAW_W   = 13;
    localparam int TEMP_W  = 12;
    localparam int HUMID_W = 10;
    localparam int GAIN_W  = 16;
    localparam int OFS_W   = 11;
    localparam int CFG_W   = 16;
    localparam int TIMER_W = 18;
    localparam int PROD_W  = GAIN_W + RAW_W;
    localparam int FRAC_W  = 14;
    localparam int CAL_W   = PROD_W - FRAC_W + 1;
    localparam int IDX_W   = 3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_TICK_MS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_MS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_READ_IVL_MS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TEMP_GAIN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEMP_OFFSET  = 3'd4;
    localparam logic [IDX_W-1:0] REG_HUMID_GAIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_HUMID_OFFSET = 3'd6;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0]  RST_TICK_MS     = 16'd100;
    localparam logic [CFG_W-1:0]  RST_WINDOW_MS   = 16'd60000;
    localparam logic [CFG_W-1:0]  RST_READ_IVL_MS = 16'd2000;
    localparam logic [GAIN_W-1:0] RST_GAIN        = 16'd16384;
    localparam logic [OFS_W-1:0]  RST_OFFSET      = 11'd0;

    // Control bundle from the sequencer to each lane.
    typedef struct packed {
        logic mul_en;  // register the calibration product of the input
        logic acc_en;  // add the calibrated value and start the division
        logic clr_en;  // window closes: clear the sum afterwards
    } lane_ctl_t;

endpackage

`default_nettype wire

### rtl/core/csw_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, quotient
// truncated toward zero. Depends on csw_avg_pkg.
`default_nettype none

module csw_div
    import csw_avg_pkg::*;
#(
    parameter int CNT_W = 11,
    parameter int SUM_W = MEAN_W + CNT_W
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]        divisor,
    output logic signed [MEAN_W-1:0]     quotient,
    output logic                         done
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg,  busy_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [SUM_W-1:0]  q_reg,     q_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  d_reg,     d_next;
    logic              neg_reg,   neg_next;
    logic              done_reg,  done_next;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  q_signed;

    // Magnitude of the dividend; the most negative value still fits unsigned.
    assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, q_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    // One restoring step per cycle.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            q_next    = mag;
            rem_next  = '0;
            d_next    = divisor;
            neg_next  = dividend[SUM_W-1];
        end else if (busy_reg) begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, d_reg}) : trial[CNT_W-1:0];
            q_next    = {q_reg[SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // Apply the sign; the mean always fits the output width.
    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[MEAN_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

### rtl/core/csw_lane.sv
// One measurement lane: calibration multiply, saturation, window sum and
// running mean through a serial divider. Depends on csw_avg_pkg and csw_div.
`default_nettype none

module csw_lane
    import csw_avg_pkg::*;
#(
    parameter int CNT_W = 11
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lane_ctl_t                ctl,
    input  wire logic signed [RAW_W-1:0]  raw,
    input  wire logic signed [GAIN_W-1:0] gain,
    input  wire logic signed [OFS_W-1:0]  offset,
    input  wire logic [CNT_W-1:0]         divisor,
    output logic signed [MEAN_W-1:0]      mean,
    output logic                          done
);

    localparam int SUM_W = MEAN_W + CNT_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [MEAN_W-1:0] mean_reg;
    logic signed [CAL_W-1:0]  shifted;
    logic signed [CAL_W:0]    cal_wide;
    logic signed [MEAN_W-1:0] cal;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [MEAN_W-1:0] quotient;
    logic                     div_done;

    // Calibration product, registered before the rest of the arithmetic.
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= gain * raw;
        end
    end

    // Drop the fraction bits (floor), add the offset and saturate.
    assign shifted  = CAL_W'(prod_reg >>> FRAC_W);
    assign cal_wide = (CAL_W+1)'(shifted) + (CAL_W+1)'(offset);
    always_comb begin
        if (cal_wide < (CAL_W+1)'(MEAN_MIN)) begin
            cal = MEAN_MIN;
        end else if (cal_wide > (CAL_W+1)'(MEAN_MAX)) begin
            cal = MEAN_MAX;
        end else begin
            cal = cal_wide[MEAN_W-1:0];
        end
    end

    assign sum_add = sum_reg + SUM_W'(cal);

    // Window sum: accumulate, and clear when the window closes.
    always_comb begin
        sum_next = sum_reg;
        if (ctl.clr_en) begin
            sum_next = '0;
        end else if (ctl.acc_en) begin
            sum_next = sum_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            mean_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            if (div_done) begin
                mean_reg <= quotient;
            end
        end
    end

    csw_div #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.acc_en),
        .dividend (sum_add),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign mean = mean_reg;
    assign done = div_done;

endmodule

`default_nettype wire

### rtl/core/calibrated_sensor_window_average.sv
// Calibrated sensor window average: timers, sequencer, two measurement lanes
// and the merging output register. Depends on csw_avg_pkg and csw_lane.
// Ticks with a sample taken pass through the accumulate and divide states and
// wait for the serial dividers; other ticks go straight to the done state.
// Throughput: one tick at a time; the next may be accepted once the result
// has reached the output register. Synchronous active-low reset clears the
// timers, sums, count and means and restores the register reset values.
`default_nettype none

module calibrated_sensor_window_average
    import csw_avg_pkg::*;
#(
    parameter int MAX_COUNT = 1024
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port.
    input  wire logic                      cfg_we,
    input  wire logic [IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    // Input channel.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [TEMP_W-1:0]  s_temp_raw,
    input  wire logic [HUMID_W-1:0]        s_humid_raw,
    input  wire logic                      s_sample_ok,
    // Result channel.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [MEAN_W-1:0]       m_temp_mean,
    output logic signed [MEAN_W-1:0]       m_humid_mean,
    output logic                           m_read_failed,
    output logic                           m_window_end
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CFG_W-1:0]         tick_ms_reg;
    logic [CFG_W-1:0]         window_ms_reg;
    logic [CFG_W-1:0]         read_ivl_reg;
    logic signed [GAIN_W-1:0] temp_gain_reg;
    logic signed [OFS_W-1:0]  temp_offset_reg;
    logic signed [GAIN_W-1:0] humid_gain_reg;
    logic signed [OFS_W-1:0]  humid_offset_reg;

    logic [TIMER_W-1:0] read_timer_reg, read_timer_next;
    logic [TIMER_W-1:0] window_timer_reg, window_timer_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               failed_reg, failed_next;
    logic               wend_reg, wend_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [MEAN_W-1:0] out_temp_reg, out_humid_reg;
    logic               out_failed_reg, out_wend_reg;

    logic               accept;
    logic               due;
    logic               take;
    logic               wend_now;
    logic               load_out;
    logic [TIMER_W:0]   read_sum;
    logic [TIMER_W:0]   window_sum;
    logic [CNT_W-1:0]   divisor;
    lane_ctl_t          lane_ctl;
    logic signed [MEAN_W-1:0] temp_mean, humid_mean;
    logic               temp_done, humid_done;
    logic signed [RAW_W-1:0]  temp_raw_ext, humid_raw_ext;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ms_reg      <= RST_TICK_MS;
            window_ms_reg    <= RST_WINDOW_MS;
            read_ivl_reg     <= RST_READ_IVL_MS;
            temp_gain_reg    <= RST_GAIN;
            temp_offset_reg  <= RST_OFFSET;
            humid_gain_reg   <= RST_GAIN;
            humid_offset_reg <= RST_OFFSET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TICK_MS:      tick_ms_reg      <= cfg_data;
                REG_WINDOW_MS:    window_ms_reg    <= cfg_data;
                REG_READ_IVL_MS:  read_ivl_reg     <= cfg_data;
                REG_TEMP_GAIN:    temp_gain_reg    <= cfg_data;
                REG_TEMP_OFFSET:  temp_offset_reg  <= cfg_data[OFS_W-1:0];
                REG_HUMID_GAIN:   humid_gain_reg   <= cfg_data;
                REG_HUMID_OFFSET: humid_offset_reg <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick decisions made at the input transfer.
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign due      = read_timer_reg >= TIMER_W'(read_ivl_reg);
    assign take     = due && s_sample_ok && (count_reg < CNT_W'(MAX_COUNT));
    assign wend_now = window_timer_reg > TIMER_W'(window_ms_reg);

    // Saturating timer advance.
    assign read_sum   = (TIMER_W+1)'(read_timer_reg) + (TIMER_W+1)'(tick_ms_reg);
    assign window_sum = (TIMER_W+1)'(window_timer_reg) + (TIMER_W+1)'(tick_ms_reg);

    assign divisor  = count_reg + 1'b1;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    // Sequencer and tick state.
    always_comb begin
        state_next        = state_reg;
        read_timer_next   = read_timer_reg;
        window_timer_next = window_timer_reg;
        count_next        = count_reg;
        failed_next       = failed_reg;
        wend_next         = wend_reg;
        lane_ctl          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    failed_next = due && !s_sample_ok;
                    wend_next   = wend_now;
                    if (due) begin
                        read_timer_next = TIMER_W'(tick_ms_reg);
                    end else if (read_sum > (TIMER_W+1)'(TIMER_MAX)) begin
                        read_timer_next = TIMER_MAX;
                    end else begin
                        read_timer_next = read_sum[TIMER_W-1:0];
                    end
                    if (wend_now) begin
                        window_timer_next = TIMER_W'(tick_ms_reg);
                    end else if (window_sum > (TIMER_W+1)'(TIMER_MAX)) begin
                        window_timer_next = TIMER_MAX;
                    end else begin
                        window_timer_next = window_sum[TIMER_W-1:0];
                    end
                    lane_ctl.mul_en = take;
                    if (take) begin
                        state_next = ST_ACC;
                    end else begin
                        lane_ctl.clr_en = wend_now;
                        if (wend_now) begin
                            count_next = '0;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACC: begin
                lane_ctl.acc_en = 1'b1;
                lane_ctl.clr_en = wend_reg;
                count_next      = wend_reg ? '0 : divisor;
                state_next      = ST_DIV;
            end
            ST_DIV: begin
                if (temp_done && humid_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            read_timer_reg   <= '0;
            window_timer_reg <= '0;
            count_reg        <= '0;
            failed_reg       <= 1'b0;
            wend_reg         <= 1'b0;
        end else begin
            state_reg        <= state_next;
            read_timer_reg   <= read_timer_next;
            window_timer_reg <= window_timer_next;
            count_reg        <= count_next;
            failed_reg       <= failed_next;
            wend_reg         <= wend_next;
        end
    end

    // The two lanes work side by side on temperature and humidity.
    assign temp_raw_ext  = RAW_W'(s_temp_raw);
    assign humid_raw_ext = signed'(RAW_W'(s_humid_raw));

    csw_lane #(.CNT_W(CNT_W)) u_temp_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .raw     (temp_raw_ext),
        .gain    (temp_gain_reg),
        .offset  (temp_offset_reg),
        .divisor (divisor),
        .mean    (temp_mean),
        .done    (temp_done)
    );

    csw_lane #(.CNT_W(CNT_W)) u_humid_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .raw     (humid_raw_ext),
        .gain    (humid_gain_reg),
        .offset  (humid_offset_reg),
        .divisor (divisor),
        .mean    (humid_mean),
        .done    (humid_done)
    );

    // Merging stage: the output register collects both means and the flags.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_temp_reg   <= temp_mean;
            out_humid_reg  <= humid_mean;
            out_failed_reg <= failed_reg;
            out_wend_reg   <= wend_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_temp_mean   = out_temp_reg;
    assign m_humid_mean  = out_humid_reg;
    assign m_read_failed = out_failed_reg;
    assign m_window_end  = out_wend_reg;

endmodule

`default_nettype wire

### rtl/core/csw_checker.sv
// Port-level checker for the calibrated sensor window average, and the bind
// that attaches it to the top level. Depends on csw_avg_pkg.
`default_nettype none

module csw_checker
    import csw_avg_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [MEAN_W-1:0] m_temp_mean,
    input wire logic signed [MEAN_W-1:0] m_humid_mean
);

    // A stalled result keeps its means.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temp_mean) && $stable(m_humid_mean))
        else $error("result changed while stalled");

    // Only one tick is in work: after an input transfer the block is busy.
    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick accepted while busy");

    // A new result only appears after the block was busy with a tick.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a tick in work");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind calibrated_sensor_window_average csw_checker u_csw_checker (.*);

`default_nettype wire
